>>> design/fsk_frequency_id_decoder_macros.svh
// Assertion helpers for the FSK ID decoder.
`ifndef FSK_FREQUENCY_ID_DECODER_MACROS_SVH
`define FSK_FREQUENCY_ID_DECODER_MACROS_SVH

// Implication checked while out of reset.
`define FSKID_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked while out of reset.
`define FSKID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/fskid_pkg.sv
package fskid_pkg;

   localparam int FREQ_W   = 16;
   localparam int MINLEN_W = 6;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int SEGMENTS = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_THR   = 3'd0,
      CSR_ZERO_THR   = 3'd1,
      CSR_BOTTOM_THR = 3'd2,
      CSR_TOP_THR    = 3'd3,
      CSR_MIN_SEG    = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_BAND  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_READ,
      ST_ACC,
      ST_CHECK
   } state_type;

   typedef enum logic [1:0] {
      MUL_ZERO,
      MUL_BOTTOM,
      MUL_TOP
   } mul_sel_type;

   localparam logic [FREQ_W-1:0]   SYNC_THR_RESET   = 16'd14400;
   localparam logic [FREQ_W-1:0]   ZERO_THR_RESET   = 16'd11600;
   localparam logic [FREQ_W-1:0]   BOTTOM_THR_RESET = 16'd10400;
   localparam logic [FREQ_W-1:0]   TOP_THR_RESET    = 16'd12960;
   localparam logic [MINLEN_W-1:0] MIN_SEG_RESET    = 6'd15;

endpackage

>>> design/fskid_ram.sv
module fskid_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/fsk_frequency_id_decoder.sv
// Channel   Ports                                   Handshake
// request   start, busy, req_frequency              taken when start && !busy
// response  rsp_valid, rsp_decoded_id, rsp_status   one-cycle strobe, no backpressure
// config    csr_valid, csr_ready, csr_index, csr_data  written when valid && !busy
//
// A sample below the sync level, or a repeated sync, leaves busy low.
// A decoding sync with too short a segment answers without leaving idle; otherwise the
// shared multiplier computes the three bounds, then a read/add loop runs over each segment
// of the sample RAM (seg = stored samples / 8). The response strobe follows the last cycle.
// Synchronous active-high reset clears control and config; sample RAM is not cleared.
// Results cannot be stalled by the receiver.
`include "fsk_frequency_id_decoder_macros.svh"

module fsk_frequency_id_decoder #(
   parameter int BUF_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [fskid_pkg::FREQ_W-1:0]         req_frequency,
   output logic                                 rsp_valid,
   output logic [fskid_pkg::ID_W-1:0]           rsp_decoded_id,
   output logic [fskid_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fskid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fskid_pkg::FREQ_W-1:0]         csr_data
);

   localparam int IDXW  = $clog2(BUF_DEPTH);
   localparam int SEGW  = IDXW - 3;
   localparam int PRODW = fskid_pkg::FREQ_W + SEGW;
   localparam int CMPW  = (SEGW > fskid_pkg::MINLEN_W) ? SEGW : fskid_pkg::MINLEN_W;

   // configuration
   logic [fskid_pkg::FREQ_W-1:0]   sync_thr_ff, zero_thr_ff, bottom_thr_ff, top_thr_ff;
   logic [fskid_pkg::MINLEN_W-1:0] min_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_thr_ff   <= fskid_pkg::SYNC_THR_RESET;
         zero_thr_ff   <= fskid_pkg::ZERO_THR_RESET;
         bottom_thr_ff <= fskid_pkg::BOTTOM_THR_RESET;
         top_thr_ff    <= fskid_pkg::TOP_THR_RESET;
         min_seg_ff    <= fskid_pkg::MIN_SEG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fskid_pkg::CSR_SYNC_THR:   sync_thr_ff   <= csr_data;
            fskid_pkg::CSR_ZERO_THR:   zero_thr_ff   <= csr_data;
            fskid_pkg::CSR_BOTTOM_THR: bottom_thr_ff <= csr_data;
            fskid_pkg::CSR_TOP_THR:    top_thr_ff    <= csr_data;
            fskid_pkg::CSR_MIN_SEG:    min_seg_ff    <= csr_data[fskid_pkg::MINLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // hold config writes off while a decode uses the levels
   assign csr_ready = !busy;

   // control and datapath registers
   fskid_pkg::state_type   state_ff, state_in;
   fskid_pkg::mul_sel_type mul_sel_ff, mul_sel_in;
   logic [IDXW-1:0]  write_index_ff, write_index_in;
   logic             sync_seen_ff, sync_seen_in;
   logic [SEGW-1:0]  seg_ff, seg_in;
   logic [SEGW-1:0]  seg_pos_ff, seg_pos_in;
   logic [2:0]       seg_num_ff, seg_num_in;
   logic [IDXW-1:0]  rd_pos_ff, rd_pos_in;
   logic [PRODW-1:0] sum_ff, sum_in;
   logic [PRODW-1:0] zero_bound_ff, zero_bound_in;
   logic [PRODW-1:0] bottom_bound_ff, bottom_bound_in;
   logic [PRODW-1:0] top_bound_ff, top_bound_in;
   logic [fskid_pkg::ID_W-1:0]     bits_ff, bits_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [fskid_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [fskid_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                          accept;
   logic                          is_sample;
   logic                          wr_en;
   logic [fskid_pkg::FREQ_W-1:0]  rd_data;
   logic [fskid_pkg::FREQ_W-1:0]  mul_a;
   logic [PRODW-1:0]              mul_p;
   logic [SEGW-1:0]               new_seg;
   logic [fskid_pkg::ID_W-1:0]    bits_next;

   assign busy      = (state_ff != fskid_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign is_sample = (req_frequency < sync_thr_ff);
   assign wr_en     = accept && is_sample;
   assign new_seg   = write_index_ff[IDXW-1:3];
   assign bits_next = {bits_ff[fskid_pkg::ID_W-2:0], (sum_ff < zero_bound_ff)};

   fskid_ram #(
      .WIDTH (fskid_pkg::FREQ_W),
      .DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (write_index_ff),
      .wr_data (req_frequency),
      .rd_addr (rd_pos_ff),
      .rd_data (rd_data)
   );

   // shared multiplier: threshold times segment length, one bound per cycle
   always_comb begin
      unique case (mul_sel_ff)
         fskid_pkg::MUL_ZERO:   mul_a = zero_thr_ff;
         fskid_pkg::MUL_BOTTOM: mul_a = bottom_thr_ff;
         fskid_pkg::MUL_TOP:    mul_a = top_thr_ff;
         default:               mul_a = top_thr_ff;
      endcase
      mul_p = PRODW'(mul_a) * PRODW'(seg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fskid_pkg::ST_IDLE;
         write_index_ff <= '0;
         sync_seen_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_index_ff <= write_index_in;
         sync_seen_ff   <= sync_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_sel_ff      <= mul_sel_in;
      seg_ff          <= seg_in;
      seg_pos_ff      <= seg_pos_in;
      seg_num_ff      <= seg_num_in;
      rd_pos_ff       <= rd_pos_in;
      sum_ff          <= sum_in;
      zero_bound_ff   <= zero_bound_in;
      bottom_bound_ff <= bottom_bound_in;
      top_bound_ff    <= top_bound_in;
      bits_ff         <= bits_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_status_ff   <= rsp_status_in;
   end

   always_comb begin
      state_in        = state_ff;
      mul_sel_in      = mul_sel_ff;
      write_index_in  = write_index_ff;
      sync_seen_in    = sync_seen_ff;
      seg_in          = seg_ff;
      seg_pos_in      = seg_pos_ff;
      seg_num_in      = seg_num_ff;
      rd_pos_in       = rd_pos_ff;
      sum_in          = sum_ff;
      zero_bound_in   = zero_bound_ff;
      bottom_bound_in = bottom_bound_ff;
      top_bound_in    = top_bound_ff;
      bits_in         = bits_ff;
      rsp_valid_in    = 1'b0;
      rsp_id_in       = rsp_id_ff;
      rsp_status_in   = rsp_status_ff;

      unique case (state_ff)
         fskid_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_sample) begin
                  sync_seen_in = 1'b0;
                  if (write_index_ff == IDXW'(BUF_DEPTH - 1)) begin
                     write_index_in = '0;
                  end else begin
                     write_index_in = write_index_ff + 1'b1;
                  end
               end else if (!sync_seen_ff) begin
                  sync_seen_in   = 1'b1;
                  write_index_in = '0;
                  seg_in         = new_seg;
                  mul_sel_in     = fskid_pkg::MUL_ZERO;
                  seg_pos_in     = '0;
                  seg_num_in     = '0;
                  rd_pos_in      = '0;
                  sum_in         = '0;
                  bits_in        = '0;
                  if (CMPW'(new_seg) < CMPW'(min_seg_ff)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = '0;
                     rsp_status_in = fskid_pkg::STATUS_SHORT;
                  end else begin
                     state_in = fskid_pkg::ST_MUL;
                  end
               end
            end
         end

         fskid_pkg::ST_MUL: begin
            unique case (mul_sel_ff)
               fskid_pkg::MUL_ZERO: begin
                  zero_bound_in = mul_p;
                  mul_sel_in    = fskid_pkg::MUL_BOTTOM;
               end
               fskid_pkg::MUL_BOTTOM: begin
                  bottom_bound_in = mul_p;
                  mul_sel_in      = fskid_pkg::MUL_TOP;
               end
               default: begin
                  top_bound_in = mul_p;
                  // empty segments skip straight to the checks
                  state_in = (seg_ff == '0) ? fskid_pkg::ST_CHECK : fskid_pkg::ST_READ;
               end
            endcase
         end

         fskid_pkg::ST_READ: begin
            state_in = fskid_pkg::ST_ACC;
         end

         fskid_pkg::ST_ACC: begin
            sum_in    = sum_ff + PRODW'(rd_data);
            rd_pos_in = rd_pos_ff + 1'b1;
            if (seg_pos_ff == seg_ff - 1'b1) begin
               seg_pos_in = '0;
               state_in   = fskid_pkg::ST_CHECK;
            end else begin
               seg_pos_in = seg_pos_ff + 1'b1;
               state_in   = fskid_pkg::ST_READ;
            end
         end

         fskid_pkg::ST_CHECK: begin
            priority if (sum_ff < bottom_bound_ff || sum_ff > top_bound_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_status_in = fskid_pkg::STATUS_BAND;
               state_in      = fskid_pkg::ST_IDLE;
            end else if (seg_num_ff == 3'(fskid_pkg::SEGMENTS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = bits_next;
               rsp_status_in = fskid_pkg::STATUS_OK;
               state_in      = fskid_pkg::ST_IDLE;
            end else begin
               bits_in    = bits_next;
               seg_num_in = seg_num_ff + 1'b1;
               sum_in     = '0;
               state_in   = (seg_ff == '0) ? fskid_pkg::ST_CHECK : fskid_pkg::ST_READ;
            end
         end

         default: begin
            state_in = fskid_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_decoded_id = rsp_id_ff;
   assign rsp_status     = rsp_status_ff;

   `FSKID_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "response strobe repeated")
   `FSKID_ASSERT_IMP(a_busy_synced, clock, reset, busy, sync_seen_ff && (write_index_ff == '0), "decode running without sync state")
   `FSKID_ASSERT_IMP(a_err_id_zero, clock, reset, rsp_valid_ff && (rsp_status_ff != fskid_pkg::STATUS_OK), rsp_id_ff == '0, "error response carries nonzero id")
   `FSKID_ASSERT_NEXT(a_read_then_acc, clock, reset, state_ff == fskid_pkg::ST_READ, state_ff == fskid_pkg::ST_ACC, "read not followed by accumulate")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int FREQ_W    = fskid_pkg::FREQ_W;
   localparam int MINLEN_W  = fskid_pkg::MINLEN_W;
   localparam int ID_W      = fskid_pkg::ID_W;
   localparam int STATUS_W  = fskid_pkg::STATUS_W;
   localparam int CSR_IDX_W = fskid_pkg::CSR_IDX_W;
   localparam int SEGMENTS  = fskid_pkg::SEGMENTS;

   localparam int DEPTH          = 256;
   localparam int SEG_CAP        = DEPTH / SEGMENTS - 1;
   localparam int MAX_GAP        = 19;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 600;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RESULT_GOAL    = 60;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [STATUS_W-1:0] status;
   } decode_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [FREQ_W-1:0]    req_frequency;
   logic                 rsp_valid;
   logic [ID_W-1:0]      rsp_decoded_id;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FREQ_W-1:0]    csr_data;

   // predictor copy of the decoder state and levels
   logic [FREQ_W-1:0]   sample_mem [DEPTH];
   int unsigned         fill_index = 0;
   bit                  sync_latched = 1'b0;
   logic [FREQ_W-1:0]   sync_thr = fskid_pkg::SYNC_THR_RESET;
   logic [FREQ_W-1:0]   zero_thr = fskid_pkg::ZERO_THR_RESET;
   logic [FREQ_W-1:0]   bottom_thr = fskid_pkg::BOTTOM_THR_RESET;
   logic [FREQ_W-1:0]   top_thr = fskid_pkg::TOP_THR_RESET;
   logic [MINLEN_W-1:0] min_seg = fskid_pkg::MIN_SEG_RESET;

   decode_result_type expected_ids [$];
   decode_result_type due_result;
   int unsigned    items_sent = 0;
   int             results_seen = 0;
   int             fail_count = 0;
   int             quiet_cycles = 0;
   bit             idle_free = 1'b0;

   fsk_frequency_id_decoder #(
      .BUF_DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_frequency  (req_frequency),
      .rsp_valid      (rsp_valid),
      .rsp_decoded_id (rsp_decoded_id),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic decode_result_type decode_store();
      decode_result_type r;
      int unsigned seg, s, k;
      logic [63:0] total;
      logic [ID_W-1:0] bits;
      r.id = '0;
      r.status = fskid_pkg::STATUS_OK;
      bits = '0;
      seg = (fill_index & ~32'd7) >> 3;
      if (seg < min_seg) begin
         r.status = fskid_pkg::STATUS_SHORT;
         return r;
      end
      for (s = 0; s < SEGMENTS; s++) begin
         total = '0;
         for (k = 0; k < seg; k++) total += sample_mem[s * seg + k];
         // stop at the first segment out of band
         if (total < 64'(bottom_thr) * seg || total > 64'(top_thr) * seg) begin
            r.status = fskid_pkg::STATUS_BAND;
            return r;
         end
         bits = {bits[ID_W-2:0], total < 64'(zero_thr) * seg};
      end
      r.id = bits;
      return r;
   endfunction

   function automatic void track_frequency(input logic [FREQ_W-1:0] f);
      if (f < sync_thr) begin
         sync_latched = 1'b0;
         sample_mem[fill_index] = f;
         fill_index = (fill_index + 1) % DEPTH;
      end else if (!sync_latched) begin
         expected_ids.push_back(decode_store());
         fill_index = 0;
         sync_latched = 1'b1;
      end
   endfunction

   function automatic void track_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [FREQ_W-1:0] data);
      case (idx)
         fskid_pkg::CSR_SYNC_THR:   sync_thr = data;
         fskid_pkg::CSR_ZERO_THR:   zero_thr = data;
         fskid_pkg::CSR_BOTTOM_THR: bottom_thr = data;
         fskid_pkg::CSR_TOP_THR:    top_thr = data;
         fskid_pkg::CSR_MIN_SEG:    min_seg = data[MINLEN_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [FREQ_W-1:0] quiet_value();
      if (sync_thr == 0) return '0;
      return FREQ_W'($urandom_range(sync_thr - 1, 0));
   endfunction

   function automatic logic [FREQ_W-1:0] sync_value();
      return FREQ_W'($urandom_range(16'hFFFF, sync_thr));
   endfunction

   // in-band sample for one bit, kept below the sync level
   function automatic logic [FREQ_W-1:0] tone_value(input bit one);
      int unsigned lo, hi, v;
      if (one) begin
         lo = bottom_thr;
         hi = (zero_thr > bottom_thr) ? zero_thr - 1 : bottom_thr;
      end else begin
         lo = zero_thr;
         hi = (top_thr > zero_thr) ? top_thr : zero_thr;
      end
      v = $urandom_range(hi, lo);
      if (v >= sync_thr) v = (sync_thr == 0) ? 0 : sync_thr - 1;
      return FREQ_W'(v);
   endfunction

   function automatic int unsigned pick_seg();
      int unsigned lo;
      lo = (min_seg > SEG_CAP) ? SEG_CAP : min_seg;
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, SEG_CAP);
      return $urandom_range(lo, (lo + 2 > SEG_CAP) ? SEG_CAP : lo + 2);
   endfunction

   task automatic send_sample(input logic [FREQ_W-1:0] f);
      int unsigned gap;
      gap = idle_free ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_frequency <= f;
      do @(posedge clock); while (busy);
      track_frequency(f);
      items_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_ids.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
      wait_drained();
      // let any sample still in flight retire
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      track_csr(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic set_levels(input logic [FREQ_W-1:0] s, input logic [FREQ_W-1:0] z,
                             input logic [FREQ_W-1:0] b, input logic [FREQ_W-1:0] t,
                             input logic [FREQ_W-1:0] m);
      write_csr(fskid_pkg::CSR_SYNC_THR, s);
      write_csr(fskid_pkg::CSR_ZERO_THR, z);
      write_csr(fskid_pkg::CSR_BOTTOM_THR, b);
      write_csr(fskid_pkg::CSR_TOP_THR, t);
      write_csr(fskid_pkg::CSR_MIN_SEG, m);
   endtask

   task automatic send_frame(input int unsigned seg_len, input int unsigned tail,
                             input bit noisy);
      logic [ID_W-1:0] pattern;
      logic [FREQ_W-1:0] f;
      int unsigned s, k;
      pattern = ID_W'($urandom);
      for (s = 0; s < SEGMENTS; s++) begin
         for (k = 0; k < seg_len; k++) begin
            f = tone_value(pattern[ID_W-1-s]);
            if (noisy && $urandom_range(0, 15) == 0) f = quiet_value();
            send_sample(f);
         end
      end
      for (k = 0; k < tail; k++) send_sample(tone_value($urandom_range(0, 1)));
      send_sample(sync_value());
      if ($urandom_range(0, 3) == 0) send_sample(sync_value());
   endtask

   task automatic send_junk(input int unsigned count);
      int unsigned k;
      for (k = 0; k < count; k++) send_sample(quiet_value());
      send_sample(sync_value());
   endtask

   task automatic run_frames(input int unsigned item_goal);
      int unsigned first, kind;
      first = items_sent;
      while (items_sent - first < item_goal) begin
         idle_free = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 70) send_frame(pick_seg(), $urandom_range(0, 7), 1'b0);
         else if (kind < 85) send_frame(pick_seg(), $urandom_range(0, 7), 1'b1);
         else if (kind < 97) send_junk($urandom_range(0, 20));
         else send_frame(SEG_CAP, $urandom_range(0, 60), 1'b0);   // fill past the wrap
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      idle_free = 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_sample(16'hFFFF);
      send_sample(fskid_pkg::SYNC_THR_RESET);
      send_sample(16'h0000);
      send_sample(fskid_pkg::SYNC_THR_RESET - 1);
      send_sample(16'd20000);
   endtask

   task automatic test_band_decode();
      write_csr(fskid_pkg::CSR_MIN_SEG, 16'hFFC1);
      send_sample(fskid_pkg::BOTTOM_THR_RESET);
      send_sample(fskid_pkg::TOP_THR_RESET);
      send_sample(fskid_pkg::ZERO_THR_RESET);
      send_sample(fskid_pkg::ZERO_THR_RESET - 1);
      send_sample(fskid_pkg::BOTTOM_THR_RESET);
      send_sample(fskid_pkg::TOP_THR_RESET);
      send_sample(fskid_pkg::TOP_THR_RESET);
      send_sample(fskid_pkg::BOTTOM_THR_RESET + 1);
      send_sample(16'hFFFF);
   endtask

   task automatic test_out_of_band();
      send_sample(16'd11000);
      send_sample(16'd11000);
      send_sample(fskid_pkg::TOP_THR_RESET + 1);
      send_sample(fskid_pkg::BOTTOM_THR_RESET - 1);
      send_sample(16'd11000);
      send_sample(16'd12000);
      send_sample(16'd12000);
      send_sample(16'd11000);
      send_sample(fskid_pkg::SYNC_THR_RESET);
   endtask

   task automatic test_empty_store_min_zero();
      write_csr(fskid_pkg::CSR_MIN_SEG, 16'hFFC0);
      send_sample(16'd14000);
      send_sample(fskid_pkg::SYNC_THR_RESET);
   endtask

   task automatic test_random_default_levels();
      write_csr(fskid_pkg::CSR_MIN_SEG, 16'd2);
      run_frames(550);
   endtask

   task automatic test_random_levels();
      int unsigned b, z, t, s;
      b = $urandom_range(0, 40000);
      z = b + $urandom_range(1, 6000);
      t = z + $urandom_range(1, 6000);
      s = t + $urandom_range(1, 6000);
      set_levels(FREQ_W'(s), FREQ_W'(z), FREQ_W'(b), FREQ_W'(t), 16'd1);
      run_frames(400);
   endtask

   task automatic test_wide_band();
      // every sample in band; all ones, then all zeros
      set_levels(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFC3);
      run_frames(150);
      write_csr(fskid_pkg::CSR_ZERO_THR, 16'h0000);
      run_frames(150);
   endtask

   task automatic test_long_minimum();
      write_csr(fskid_pkg::CSR_MIN_SEG, 16'hFFFF);
      run_frames(150);
   endtask

   task automatic test_all_sync();
      int unsigned k;
      // clear the sync flag so the first sync decodes
      send_sample(quiet_value());
      write_csr(fskid_pkg::CSR_SYNC_THR, 16'h0000);
      for (k = 0; k < 20; k++) send_sample(FREQ_W'($urandom));
      write_csr(CSR_SPARE_IDX, FREQ_W'($urandom));
   endtask

   task automatic test_reset_levels();
      set_levels(fskid_pkg::SYNC_THR_RESET, fskid_pkg::ZERO_THR_RESET,
                 fskid_pkg::BOTTOM_THR_RESET, fskid_pkg::TOP_THR_RESET,
                 FREQ_W'(fskid_pkg::MIN_SEG_RESET));
      run_frames(300);
      while (results_seen + expected_ids.size() < RESULT_GOAL) run_frames(40);
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_frequency <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_band_decode();
      test_out_of_band();
      test_empty_store_min_zero();
      test_random_default_levels();
      test_random_levels();
      test_wide_band();
      test_long_minimum();
      test_all_sync();
      test_reset_levels();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("fsk_frequency_id_decoder regression: pass");
      end else begin
         $display("fsk_frequency_id_decoder regression: fail");
      end
      $finish;
   end

   // check each result beat against the oldest prediction; watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_ids.size() == 0) begin
               $error("unexpected result: decoded_id %0d status %0d", rsp_decoded_id,
                      rsp_status);
               fail_count++;
            end else begin
               due_result = expected_ids.pop_front();
               results_seen++;
               if (rsp_decoded_id !== due_result.id) begin
                  $error("decoded_id: expected %0d, actual %0d", due_result.id,
                         rsp_decoded_id);
                  fail_count++;
               end
               if (rsp_status !== due_result.status) begin
                  $error("status: expected %0d, actual %0d", due_result.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("fsk_frequency_id_decoder regression: fail");
            $finish;
         end
      end
   end

endmodule
